[design/gms_pkg.sv]
`default_nettype none

package gms_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_AUTO_CLOSE_MODE    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SHORT_CLOSE_TICKS  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MEDIUM_CLOSE_TICKS = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LONG_CLOSE_TICKS   = 2'd3;

    localparam int TICKS_BITS = 16;
    localparam int MODE_BITS  = 2;

    // Register reset values
    localparam logic [MODE_BITS-1:0]  MODE_RESET         = 2'd0;
    localparam logic [TICKS_BITS-1:0] SHORT_TICKS_RESET  = 16'd8000;
    localparam logic [TICKS_BITS-1:0] MEDIUM_TICKS_RESET = 16'd18000;
    localparam logic [TICKS_BITS-1:0] LONG_TICKS_RESET   = 16'd30000;

    // Default auto-close counter width
    localparam int COUNT_BITS_DEFAULT = 16;

    // Reported phase codes
    localparam int PHASE_BITS = 3;
    localparam logic [PHASE_BITS-1:0] PHASE_IDLE         = 3'd0;
    localparam logic [PHASE_BITS-1:0] PHASE_OPENING      = 3'd1;
    localparam logic [PHASE_BITS-1:0] PHASE_PAUSED       = 3'd2;
    localparam logic [PHASE_BITS-1:0] PHASE_CLOSING      = 3'd3;
    localparam logic [PHASE_BITS-1:0] PHASE_OPEN_WAITING = 3'd4;

    // DIP switch settings of auto_close_mode
    localparam logic [MODE_BITS-1:0] MODE_OFF    = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_SHORT  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_LONG   = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_MEDIUM = 2'd3;

    typedef struct packed {
        logic button_low;
        logic key_switch_low;
        logic open_limit;
        logic close_limit;
        logic beam_blocked;
        logic tick;
    } gms_sample_t;

    typedef struct packed {
        logic opening;
        logic paused;
        logic closing;
        logic open_waiting;
        logic counting_enabled;
        logic button_held;
        logic button_request;
        logic open_out;
        logic close_out;
    } gms_flags_t;

    typedef struct packed {
        logic [MODE_BITS-1:0]  auto_close_mode;
        logic [TICKS_BITS-1:0] short_close_ticks;
        logic [TICKS_BITS-1:0] medium_close_ticks;
        logic [TICKS_BITS-1:0] long_close_ticks;
    } gms_cfg_t;

endpackage

`default_nettype wire

[design/gms_cfg_regs.sv]
`default_nettype none

module gms_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [gms_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [gms_pkg::TICKS_BITS-1:0]     cfg_data,
    output gms_pkg::gms_cfg_t                       cfg
);
    import gms_pkg::*;

    gms_cfg_t cfg_reg;
    logic     write_en;

    // Writes are always taken
    assign cfg_ready = 1'b1;
    assign write_en  = cfg_valid && cfg_ready;
    assign cfg       = cfg_reg;

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.auto_close_mode    <= MODE_RESET;
            cfg_reg.short_close_ticks  <= SHORT_TICKS_RESET;
            cfg_reg.medium_close_ticks <= MEDIUM_TICKS_RESET;
            cfg_reg.long_close_ticks   <= LONG_TICKS_RESET;
        end
        else if (write_en)
        begin
            case (cfg_index)
                CFG_AUTO_CLOSE_MODE:    cfg_reg.auto_close_mode <= cfg_data[MODE_BITS-1:0];
                CFG_SHORT_CLOSE_TICKS:  cfg_reg.short_close_ticks <= cfg_data;
                CFG_MEDIUM_CLOSE_TICKS: cfg_reg.medium_close_ticks <= cfg_data;
                CFG_LONG_CLOSE_TICKS:   cfg_reg.long_close_ticks <= cfg_data;
                default:                cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

[design/gms_step.sv]
`default_nettype none

module gms_step #(
    parameter int COUNT_BITS = gms_pkg::COUNT_BITS_DEFAULT
) (
    input  wire gms_pkg::gms_sample_t           sample,
    input  wire gms_pkg::gms_cfg_t              cfg,
    input  wire gms_pkg::gms_flags_t            flags,
    input  wire logic [COUNT_BITS-1:0]          count,
    output gms_pkg::gms_flags_t                 flags_next,
    output logic [COUNT_BITS-1:0]               count_next,
    output logic [gms_pkg::PHASE_BITS-1:0]      phase
);
    import gms_pkg::*;

    // Compare width wide enough for both the counter and a threshold
    localparam int CMP_BITS = (COUNT_BITS > TICKS_BITS) ? COUNT_BITS : TICKS_BITS;

    logic                  threshold_hit;
    logic [TICKS_BITS-1:0] threshold;
    logic                  clear_pause;

    // Threshold selected by the DIP mode
    always_comb
    begin
        case (cfg.auto_close_mode)
            MODE_SHORT:
            begin
                threshold   = cfg.short_close_ticks;
                clear_pause = 1'b0;
            end
            MODE_MEDIUM:
            begin
                threshold   = cfg.medium_close_ticks;
                clear_pause = 1'b1;
            end
            MODE_LONG:
            begin
                threshold   = cfg.long_close_ticks;
                clear_pause = 1'b1;
            end
            default:
            begin
                threshold   = cfg.short_close_ticks;
                clear_pause = 1'b0;
            end
        endcase
    end

    // Priority chain of gate rules, each seeing the flags left by the one before
    always_comb
    begin
        gms_flags_t            f;
        logic [COUNT_BITS-1:0] c;
        logic                  pressed;
        logic                  key_on;

        f       = flags;
        c       = count;
        pressed = !sample.button_low;
        key_on  = !sample.key_switch_low;

        // button edge latch
        if (pressed && !f.button_held)
        begin
            f.button_request = 1'b1;
            f.button_held    = 1'b1;
        end
        else if (!pressed)
        begin
            f.button_held = 1'b0;
        end

        if (f.counting_enabled && sample.tick)
            c = c + COUNT_BITS'(1);
        if (sample.beam_blocked)
            c = '0;

        // start
        if (!f.opening && !f.closing && !sample.open_limit && !f.open_waiting &&
            !f.paused && (key_on || f.button_request))
        begin
            f.open_out       = 1'b1;
            f.button_request = 1'b0;
            f.opening        = 1'b1;
        end
        // pause while opening
        if (f.opening && (key_on || f.button_request))
        begin
            f.open_out       = 1'b0;
            f.button_request = 1'b0;
            f.opening        = 1'b0;
            f.paused         = 1'b1;
        end
        // reopen from pause when someone is in the gateway
        if (f.paused && sample.beam_blocked && (key_on || f.button_request))
        begin
            f.open_out       = 1'b1;
            f.button_request = 1'b0;
            f.opening        = 1'b1;
        end
        // close from pause
        if (!sample.beam_blocked && f.paused && (key_on || f.button_request))
        begin
            f.close_out      = 1'b1;
            f.button_request = 1'b0;
            f.paused         = 1'b0;
            f.closing        = 1'b1;
        end
        // reverse on command while closing
        if (f.closing && (key_on || f.button_request))
        begin
            f.close_out      = 1'b0;
            f.button_request = 1'b0;
            f.open_out       = 1'b1;
            f.opening        = 1'b1;
            f.closing        = 1'b0;
        end
        // manual close while open and waiting
        if (f.open_waiting && (key_on || f.button_request))
        begin
            f.close_out        = 1'b1;
            f.button_request   = 1'b0;
            f.closing          = 1'b1;
            c                  = '0;
            f.counting_enabled = 1'b0;
            f.open_waiting     = 1'b0;
        end
        // open limit
        if (f.opening && sample.open_limit)
        begin
            f.open_out     = 1'b0;
            f.opening      = 1'b0;
            f.open_waiting = 1'b1;
        end
        // close limit
        if (f.closing && sample.close_limit)
        begin
            f.close_out = 1'b0;
            f.closing   = 1'b0;
        end
        // obstruction while closing
        if (f.closing && sample.beam_blocked)
        begin
            f.close_out = 1'b0;
            f.closing   = 1'b0;
            f.open_out  = 1'b1;
            f.opening   = 1'b1;
        end

        // auto close; the DIP settings are mutually exclusive so one rule runs
        threshold_hit = (CMP_BITS'(c) == CMP_BITS'(threshold));
        if ((cfg.auto_close_mode != MODE_OFF) && f.open_waiting)
        begin
            f.counting_enabled = 1'b1;
            if (threshold_hit)
            begin
                f.close_out = 1'b1;
                f.closing   = 1'b1;
                if (clear_pause)
                    f.paused = 1'b0;
                c                  = '0;
                f.counting_enabled = 1'b0;
                f.open_waiting     = 1'b0;
            end
        end

        flags_next = f;
        count_next = c;

        if (f.opening)
            phase = PHASE_OPENING;
        else if (f.closing)
            phase = PHASE_CLOSING;
        else if (f.paused)
            phase = PHASE_PAUSED;
        else if (f.open_waiting)
            phase = PHASE_OPEN_WAITING;
        else
            phase = PHASE_IDLE;
    end

endmodule

`default_nettype wire

[design/gate_motor_sequencer_core.sv]
`default_nettype none

// Gate motor sequencer: takes one sample of the gate inputs (button, key
// switch, limit switches, photocell, millisecond tick) per transaction and
// returns one transaction with the relay levels and the gate phase after that
// sample. A new sample is taken every clock cycle unless sample_stall is
// high; each result passes the input register, then the result register.
// The throughput of one sample per cycle is set by the loop through the
// rule chain that updates the gate flags and the auto-close counter.
// Configuration writes are always accepted (cfg_ready is tied high)
// and must only be issued while no sample is in flight.
module gate_motor_sequencer_core #(
    parameter int COUNT_BITS = gms_pkg::COUNT_BITS_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // sample channel
    input  wire logic                               sample_valid,
    output logic                                    sample_stall,
    input  wire logic                               button_low,
    input  wire logic                               key_switch_low,
    input  wire logic                               open_limit,
    input  wire logic                               close_limit,
    input  wire logic                               beam_blocked,
    input  wire logic                               tick,
    // result channel
    output logic                                    result_valid,
    input  wire logic                               result_stall,
    output logic                                    open_drive,
    output logic                                    close_drive,
    output logic [gms_pkg::PHASE_BITS-1:0]          phase,
    // configuration channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [gms_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [gms_pkg::TICKS_BITS-1:0]     cfg_data
);
    import gms_pkg::*;

    gms_cfg_t              cfg;
    gms_sample_t           sample_reg;
    logic                  sample_valid_reg;
    gms_flags_t            flags_reg;
    gms_flags_t            flags_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [PHASE_BITS-1:0] phase_next;
    logic                  open_drive_reg;
    logic                  close_drive_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic                  result_valid_reg;
    logic                  result_free;
    logic                  step_fire;
    logic                  sample_fire;

    gms_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gms_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .sample     (sample_reg),
        .cfg        (cfg),
        .flags      (flags_reg),
        .count      (count_reg),
        .flags_next (flags_next),
        .count_next (count_next),
        .phase      (phase_next)
    );

    // Pipeline flow control
    assign result_free  = !result_valid_reg || !result_stall;
    assign step_fire    = sample_valid_reg && result_free;
    assign sample_stall = sample_valid_reg && !result_free;
    assign sample_fire  = sample_valid && !sample_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sample_valid_reg <= 1'b0;
        else if (!sample_stall)
            sample_valid_reg <= sample_valid;
    end

    always_ff @(posedge clk)
    begin
        if (sample_fire)
        begin
            sample_reg.button_low     <= button_low;
            sample_reg.key_switch_low <= key_switch_low;
            sample_reg.open_limit     <= open_limit;
            sample_reg.close_limit    <= close_limit;
            sample_reg.beam_blocked   <= beam_blocked;
            sample_reg.tick           <= tick;
        end
    end

    // Gate state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            count_reg <= '0;
        end
        else if (step_fire)
        begin
            flags_reg <= flags_next;
            count_reg <= count_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (result_free)
            result_valid_reg <= sample_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            open_drive_reg  <= flags_next.open_out;
            close_drive_reg <= flags_next.close_out;
            phase_reg       <= phase_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign open_drive   = open_drive_reg;
    assign close_drive  = close_drive_reg;
    assign phase        = phase_reg;

    // Checks
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (sample_valid_reg && result_valid_reg))
        else $error("sample stalled while a pipeline stage is empty");

    a_sample_enters: assert property (@(posedge clk) disable iff (!rst_n)
        sample_fire |=> sample_valid_reg)
        else $error("accepted sample not held in input register");

    a_step_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire |=> result_valid_reg)
        else $error("processed sample did not produce a result");

    a_beam_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && sample_reg.beam_blocked) |=> (count_reg == '0))
        else $error("auto-close count not cleared by photocell");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (phase_reg <= PHASE_OPEN_WAITING))
        else $error("phase code out of range");

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import gms_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    // ticks counted with auto close off before a matching threshold is set
    localparam int OFF_TICKS   = 20;

    typedef struct packed {
        logic                  open_drive;
        logic                  close_drive;
        logic [PHASE_BITS-1:0] phase;
    } gate_drive_t;

    logic                      clk            = 1'b0;
    logic                      rst_n          = 1'b0;
    logic                      sample_valid   = 1'b0;
    logic                      sample_stall;
    logic                      button_low     = 1'b1;
    logic                      key_switch_low = 1'b1;
    logic                      open_limit     = 1'b0;
    logic                      close_limit    = 1'b0;
    logic                      beam_blocked   = 1'b0;
    logic                      tick           = 1'b0;
    logic                      result_valid;
    logic                      result_stall   = 1'b0;
    logic                      open_drive;
    logic                      close_drive;
    logic [PHASE_BITS-1:0]     phase;
    logic                      cfg_valid      = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index      = '0;
    logic [TICKS_BITS-1:0]     cfg_data       = '0;

    gate_motor_sequencer_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .button_low     (button_low),
        .key_switch_low (key_switch_low),
        .open_limit     (open_limit),
        .close_limit    (close_limit),
        .beam_blocked   (beam_blocked),
        .tick           (tick),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .open_drive     (open_drive),
        .close_drive    (close_drive),
        .phase          (phase),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Gate controller state as seen by the predictor
    gms_cfg_t                      gate_cfg = '{MODE_RESET, SHORT_TICKS_RESET,
                                                MEDIUM_TICKS_RESET, LONG_TICKS_RESET};
    gms_flags_t                    gate_flags  = '0;
    logic [COUNT_BITS_DEFAULT-1:0] close_count = '0;
    gate_drive_t                   expected_drives[$];

    bit idle_enabled   = 1'b1;
    int hold_off_left  = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // key switch is level sensitive, the button only counts once per press
    function automatic bit command_on(input bit key_on);
        return key_on || gate_flags.button_request;
    endfunction

    function automatic void auto_close(input logic [TICKS_BITS-1:0] limit,
                                       input bit clear_pause);
        gate_flags.counting_enabled = 1'b1;
        if (close_count == limit)
        begin
            gate_flags.close_out        = 1'b1;
            gate_flags.closing          = 1'b1;
            if (clear_pause)
                gate_flags.paused = 1'b0;
            close_count                 = '0;
            gate_flags.counting_enabled = 1'b0;
            gate_flags.open_waiting     = 1'b0;
        end
    endfunction

    // one pin sample through the rule chain; later rules see updated flags
    function automatic gate_drive_t advance_gate(input gms_sample_t s);
        gate_drive_t d;
        bit          pressed;
        bit          key_on;
        pressed = !s.button_low;
        key_on  = !s.key_switch_low;

        // button edge latch
        if (pressed && !gate_flags.button_held)
        begin
            gate_flags.button_request = 1'b1;
            gate_flags.button_held    = 1'b1;
        end
        else if (!pressed)
            gate_flags.button_held = 1'b0;

        // tick count; the photocell clears it after any increment
        if (gate_flags.counting_enabled && s.tick)
            close_count = close_count + 1'b1;
        if (s.beam_blocked)
            close_count = '0;

        // start
        if (!gate_flags.opening && !gate_flags.closing && !s.open_limit &&
            !gate_flags.open_waiting && !gate_flags.paused && command_on(key_on))
        begin
            gate_flags.open_out       = 1'b1;
            gate_flags.button_request = 1'b0;
            gate_flags.opening        = 1'b1;
        end
        // pause while opening
        if (gate_flags.opening && command_on(key_on))
        begin
            gate_flags.open_out       = 1'b0;
            gate_flags.button_request = 1'b0;
            gate_flags.opening        = 1'b0;
            gate_flags.paused         = 1'b1;
        end
        // reopen from pause with someone in the gateway; paused stays set
        if (gate_flags.paused && s.beam_blocked && command_on(key_on))
        begin
            gate_flags.open_out       = 1'b1;
            gate_flags.button_request = 1'b0;
            gate_flags.opening        = 1'b1;
        end
        // close from pause
        if (!s.beam_blocked && gate_flags.paused && command_on(key_on))
        begin
            gate_flags.close_out      = 1'b1;
            gate_flags.button_request = 1'b0;
            gate_flags.paused         = 1'b0;
            gate_flags.closing        = 1'b1;
        end
        // reverse on command while closing
        if (gate_flags.closing && command_on(key_on))
        begin
            gate_flags.close_out      = 1'b0;
            gate_flags.button_request = 1'b0;
            gate_flags.open_out       = 1'b1;
            gate_flags.opening        = 1'b1;
            gate_flags.closing        = 1'b0;
        end
        // manual close while open and waiting
        if (gate_flags.open_waiting && command_on(key_on))
        begin
            gate_flags.close_out        = 1'b1;
            gate_flags.button_request   = 1'b0;
            gate_flags.closing          = 1'b1;
            close_count                 = '0;
            gate_flags.counting_enabled = 1'b0;
            gate_flags.open_waiting     = 1'b0;
        end
        // end limits
        if (gate_flags.opening && s.open_limit)
        begin
            gate_flags.open_out     = 1'b0;
            gate_flags.opening      = 1'b0;
            gate_flags.open_waiting = 1'b1;
        end
        if (gate_flags.closing && s.close_limit)
        begin
            gate_flags.close_out = 1'b0;
            gate_flags.closing   = 1'b0;
        end
        // obstruction while closing
        if (gate_flags.closing && s.beam_blocked)
        begin
            gate_flags.close_out = 1'b0;
            gate_flags.closing   = 1'b0;
            gate_flags.open_out  = 1'b1;
            gate_flags.opening   = 1'b1;
        end

        // auto close, threshold picked by the DIP mode
        if (gate_cfg.auto_close_mode == MODE_SHORT && gate_flags.open_waiting)
            auto_close(gate_cfg.short_close_ticks, 1'b0);
        if (gate_cfg.auto_close_mode == MODE_MEDIUM && gate_flags.open_waiting)
            auto_close(gate_cfg.medium_close_ticks, 1'b1);
        if (gate_cfg.auto_close_mode == MODE_LONG && gate_flags.open_waiting)
            auto_close(gate_cfg.long_close_ticks, 1'b1);

        d.open_drive  = gate_flags.open_out;
        d.close_drive = gate_flags.close_out;
        if (gate_flags.opening)
            d.phase = PHASE_OPENING;
        else if (gate_flags.closing)
            d.phase = PHASE_CLOSING;
        else if (gate_flags.paused)
            d.phase = PHASE_PAUSED;
        else if (gate_flags.open_waiting)
            d.phase = PHASE_OPEN_WAITING;
        else
            d.phase = PHASE_IDLE;
        return d;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // pin sample from active-high intents
    function automatic gms_sample_t pin_levels(input bit press, input bit key,
                                               input bit olim, input bit clim,
                                               input bit beam, input bit tk);
        gms_sample_t s;
        s.button_low     = !press;
        s.key_switch_low = !key;
        s.open_limit     = olim;
        s.close_limit    = clim;
        s.beam_blocked   = beam;
        s.tick           = tk;
        return s;
    endfunction

    // mostly plausible pin activity, some raw noise
    function automatic gms_sample_t random_sample();
        if ($urandom_range(0, 4) == 0)
            return gms_sample_t'(6'($urandom_range(0, 63)));
        return pin_levels($urandom_range(0, 99) < 12, $urandom_range(0, 99) < 6,
                          $urandom_range(0, 99) < 12, $urandom_range(0, 99) < 12,
                          $urandom_range(0, 99) < 8,  $urandom_range(0, 99) < 60);
    endfunction

    // one sample transaction; returns at the accepting edge
    task automatic send_sample(input gms_sample_t s);
        int gap;
        gap = idle_enabled ? $urandom_range(0, 8) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            sample_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        {button_low, key_switch_low, open_limit, close_limit, beam_blocked, tick} = s;
        sample_valid = 1'b1;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        expected_drives.push_back(advance_gate(s));
    endtask

    // stop offering samples and wait for every outstanding result
    task automatic wait_for_drain();
        @(negedge clk);
        sample_valid = 1'b0;
        while (expected_drives.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] index,
                             input logic [TICKS_BITS-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (index)
            CFG_AUTO_CLOSE_MODE:    gate_cfg.auto_close_mode    = value[MODE_BITS-1:0];
            CFG_SHORT_CLOSE_TICKS:  gate_cfg.short_close_ticks  = value;
            CFG_MEDIUM_CLOSE_TICKS: gate_cfg.medium_close_ticks = value;
            CFG_LONG_CLOSE_TICKS:   gate_cfg.long_close_ticks   = value;
            default:                ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_settings(input logic [MODE_BITS-1:0] mode,
                                  input logic [TICKS_BITS-1:0] short_t,
                                  input logic [TICKS_BITS-1:0] medium_t,
                                  input logic [TICKS_BITS-1:0] long_t);
        wait_for_drain();
        cfg_write(CFG_AUTO_CLOSE_MODE, mode);
        cfg_write(CFG_SHORT_CLOSE_TICKS, short_t);
        cfg_write(CFG_MEDIUM_CLOSE_TICKS, medium_t);
        cfg_write(CFG_LONG_CLOSE_TICKS, long_t);
    endtask

    task automatic run_random_phase(input logic [MODE_BITS-1:0] mode,
                                    input logic [TICKS_BITS-1:0] short_t,
                                    input logic [TICKS_BITS-1:0] medium_t,
                                    input logic [TICKS_BITS-1:0] long_t,
                                    input bit idle, input int count);
        apply_settings(mode, short_t, medium_t, long_t);
        idle_enabled = idle;
        repeat (count)
            send_sample(random_sample());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // manual sequences with auto close off: start, held button, pause,
    // reopen on beam, close from pause, obstruction, manual close, reversal
    task automatic test_open_pause_close();
        send_sample(pin_levels(0, 0, 0, 0, 0, 0));
        send_sample(pin_levels(1, 0, 0, 0, 0, 0));
        send_sample(pin_levels(1, 0, 0, 0, 0, 0));
        send_sample(pin_levels(0, 0, 0, 0, 0, 0));
        send_sample(pin_levels(1, 0, 0, 0, 0, 0));
        send_sample(pin_levels(0, 1, 0, 0, 1, 0));
        // open limit while paused is still set: reported as paused
        send_sample(pin_levels(0, 0, 1, 0, 0, 0));
        send_sample(pin_levels(1, 0, 0, 0, 0, 0));
        send_sample(pin_levels(0, 0, 0, 0, 1, 0));
        send_sample(pin_levels(0, 0, 1, 0, 0, 0));
        send_sample(pin_levels(1, 0, 0, 0, 0, 0));
        send_sample(pin_levels(0, 1, 0, 0, 0, 0));
        send_sample(pin_levels(0, 0, 1, 0, 0, 0));
        send_sample(pin_levels(0, 1, 0, 0, 0, 0));
        send_sample(pin_levels(0, 0, 0, 1, 0, 0));
    endtask

    // each DIP mode with a tiny threshold, threshold zero, beam clearing the count
    task automatic test_auto_close_thresholds();
        apply_settings(MODE_SHORT, 16'd2, MEDIUM_TICKS_RESET, LONG_TICKS_RESET);
        send_sample(pin_levels(1, 0, 0, 0, 0, 0));
        send_sample(pin_levels(0, 0, 1, 0, 0, 0));
        send_sample(pin_levels(0, 0, 0, 0, 0, 1));
        send_sample(pin_levels(0, 0, 0, 0, 1, 1));
        send_sample(pin_levels(0, 0, 0, 0, 0, 1));
        send_sample(pin_levels(0, 0, 0, 0, 0, 1));
        // tick while not counting is ignored
        send_sample(pin_levels(0, 0, 0, 1, 0, 1));

        apply_settings(MODE_MEDIUM, 16'd2, 16'd0, LONG_TICKS_RESET);
        send_sample(pin_levels(1, 0, 0, 0, 0, 0));
        send_sample(pin_levels(0, 0, 1, 0, 0, 0));
        send_sample(pin_levels(0, 0, 0, 1, 0, 0));

        apply_settings(MODE_LONG, 16'd2, 16'd0, 16'd1);
        send_sample(pin_levels(1, 0, 0, 0, 0, 0));
        send_sample(pin_levels(0, 0, 1, 0, 0, 0));
        send_sample(pin_levels(0, 0, 0, 0, 0, 1));
        send_sample(pin_levels(0, 0, 0, 1, 0, 0));
    endtask

    // counting left on after switching to mode off; the count carries on and
    // closes the gate as soon as a matching threshold is switched back in
    task automatic test_mode_off_counting();
        apply_settings(MODE_SHORT, 16'hFFFF, MEDIUM_TICKS_RESET, LONG_TICKS_RESET);
        send_sample(pin_levels(1, 0, 0, 0, 0, 0));
        send_sample(pin_levels(0, 0, 1, 0, 0, 0));
        wait_for_drain();
        cfg_write(CFG_AUTO_CLOSE_MODE, MODE_OFF);
        idle_enabled = 1'b0;
        repeat (OFF_TICKS)
            send_sample(pin_levels(0, 0, 0, 0, 0, 1));
        wait_for_drain();
        cfg_write(CFG_SHORT_CLOSE_TICKS, TICKS_BITS'(OFF_TICKS + 1));
        cfg_write(CFG_AUTO_CLOSE_MODE, MODE_SHORT);
        idle_enabled = 1'b1;
        send_sample(pin_levels(0, 0, 0, 0, 0, 1));
        send_sample(pin_levels(0, 0, 0, 1, 0, 0));
    endtask

    // result side held off for a long stretch while samples keep coming
    task automatic test_backpressure();
        wait_for_drain();
        idle_enabled  = 1'b0;
        hold_off_left = 60;
        repeat (40)
            send_sample(random_sample());
        wait_for_drain();
        idle_enabled = 1'b1;
    endtask

    task automatic test_random_settings();
        run_random_phase(MODE_SHORT,  16'd3,    16'hFFFF, 16'd0,    1'b1, 200);
        run_random_phase(MODE_MEDIUM, 16'd0,    16'd4,    16'hFFFF, 1'b0, 150);
        run_random_phase(MODE_LONG,   16'hFFFF, 16'd0,    16'd6,    1'b1, 200);
        run_random_phase(MODE_OFF,    16'd2,    16'd2,    16'd2,    1'b1, 150);
        run_random_phase(MODE_SHORT,  16'd0,    16'd0,    16'd0,    1'b0, 150);
        run_random_phase(MODE_MEDIUM, 16'd1,    16'd8,    16'd1,    1'b1, 200);
        repeat (3)
            run_random_phase(MODE_BITS'($urandom_range(0, 3)),
                             TICKS_BITS'($urandom_range(0, 10)),
                             TICKS_BITS'($urandom_range(0, 10)),
                             TICKS_BITS'($urandom_range(0, 10)), 1'b1, 150);
        idle_enabled = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // per-result random stall, plus a long hold-off when requested
    initial
    begin : result_receiver
        int wait_left;
        wait_left = 0;
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
                wait_left = idle_enabled ? $urandom_range(0, 8) : 0;
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                result_stall = 1'b1;
            end
            else if (wait_left > 0)
            begin
                wait_left--;
                result_stall = 1'b1;
            end
            else
                result_stall = 1'b0;
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin : drive_checker
        gate_drive_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_drives.size() == 0)
            begin
                $error("unexpected result: open_drive %0d close_drive %0d phase %0d",
                       open_drive, close_drive, phase);
                mismatch_count++;
            end
            else
            begin
                want = expected_drives.pop_front();
                if (open_drive !== want.open_drive)
                begin
                    $error("open_drive: expected %0d, actual %0d", want.open_drive, open_drive);
                    mismatch_count++;
                end
                if (close_drive !== want.close_drive)
                begin
                    $error("close_drive: expected %0d, actual %0d",
                           want.close_drive, close_drive);
                    mismatch_count++;
                end
                if (phase !== want.phase)
                begin
                    $error("phase: expected %0d, actual %0d", want.phase, phase);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_open_pause_close();
        test_auto_close_thresholds();
        test_mode_off_counting();
        test_backpressure();
        test_random_settings();

        wait_for_drain();
        repeat (6) @(posedge clk);
        if (mismatch_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
